FILE: hdl/length_prefixed_crc_deframer_defines.svh
// Assertion macros shared by the deframer modules.
`ifndef LENGTH_PREFIXED_CRC_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIXED_CRC_DEFRAMER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LPCD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LPCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/lpcd_pkg.sv
// Types, constants and the CRC byte update shared by the deframer modules.
package lpcd_pkg;

    typedef enum logic [2:0] {
        PH_LEN_HI  = 3'd0,
        PH_LEN_LO  = 3'd1,
        PH_CMD     = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CRC_HI  = 3'd4,
        PH_CRC_LO  = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        OP_CMD     = 3'd0,
        OP_PAYLOAD = 3'd1,
        OP_CHECK   = 3'd2,
        OP_ZERO    = 3'd3,
        OP_LONG    = 3'd4
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  data;
        logic [15:0] count;
        logic [15:0] rx_crc;
    } op_entry_t;

    localparam logic [1:0] KIND_CMD     = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_CRC  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;
    localparam logic [1:0] ST_LONG = 2'd3;

    localparam logic [15:0] CRC_POLY       = 16'h8408;
    localparam logic [16:0] HEADER_AND_CRC = 17'd4;
    localparam logic [16:0] MAX_FRAME_RESET = 17'd1024;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: hdl/length_prefixed_crc_deframer.sv
// Top level of the length-prefixed CRC-16 frame deframer.
// Input channel s_*: one stream byte per transfer. A frame is a big-endian
// 16-bit body length, the body (command byte then payload) and a big-endian
// CRC-16 of the body (reflected polynomial 0x8408, initial value zero).
// Output channel m_*: the command byte and each payload byte as they arrive,
// then one status transfer per frame (ok, CRC mismatch, zero length or too
// long). The receiver must drop the streamed bytes of a frame whose status
// is not ok. cfg_wr_en/cfg_wr_data write the largest whole frame size and
// may be written only while the block is idle.
// Throughput is one byte per cycle while the receiver keeps taking results.
// A result passes from the transfer that causes it through the operation queue
// and then the output register before it is presented on m_*.
// Length and CRC high bytes cause no result.
// When the receiver stalls, the output register holds its result, the
// operation queue fills and s_ready falls once it is full.
// Reset returns the block to waiting for a length byte, empties the queue
// and sets the frame size limit to 1024 bytes.
module length_prefixed_crc_deframer
    import lpcd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [16:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_out_kind,
    output logic [7:0]  m_out_byte,
    output logic [1:0]  m_frame_status,
    output logic [15:0] m_payload_count,
    output logic        m_frame_end
);

    logic      push_valid;
    logic      push_ready;
    op_entry_t push_entry;
    logic      pop_valid;
    logic      pop_ready;
    op_entry_t pop_entry;

    lpcd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_byte   (s_rx_byte),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_entry  (push_entry)
    );

    lpcd_fifo #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    lpcd_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .pop_valid       (pop_valid),
        .pop_ready       (pop_ready),
        .pop_entry       (pop_entry),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_kind      (m_out_kind),
        .m_out_byte      (m_out_byte),
        .m_frame_status  (m_frame_status),
        .m_payload_count (m_payload_count),
        .m_frame_end     (m_frame_end)
    );

endmodule

FILE: hdl/lpcd_front.sv
// Front end: accepts stream bytes, tracks the frame phase and queues operations.
`include "length_prefixed_crc_deframer_defines.svh"

module lpcd_front
    import lpcd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [16:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        push_valid,
    input  logic        push_ready,
    output op_entry_t   push_entry
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  length_high_reg, length_high_next;
    logic [15:0] body_length_reg, body_length_next;
    logic [15:0] body_remaining_reg, body_remaining_next;
    logic [7:0]  crc_high_reg, crc_high_next;
    logic [16:0] max_frame_bytes_reg;
    logic        accept;
    logic [15:0] len_word;
    logic [15:0] remaining_dec;
    logic        too_long;

    assign s_ready       = push_ready;
    assign accept        = s_valid && s_ready;
    assign len_word      = {length_high_reg, s_rx_byte};
    assign remaining_dec = body_remaining_reg - 16'd1;
    assign too_long      = ({1'b0, len_word} + HEADER_AND_CRC) > max_frame_bytes_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= PH_LEN_HI;
            length_high_reg     <= 8'h00;
            body_length_reg     <= 16'h0000;
            body_remaining_reg  <= 16'h0000;
            crc_high_reg        <= 8'h00;
            max_frame_bytes_reg <= MAX_FRAME_RESET;
        end else begin
            phase_reg          <= phase_next;
            length_high_reg    <= length_high_next;
            body_length_reg    <= body_length_next;
            body_remaining_reg <= body_remaining_next;
            crc_high_reg       <= crc_high_next;
            if (cfg_wr_en) begin
                max_frame_bytes_reg <= cfg_wr_data;
            end
        end
    end

    always_comb begin
        phase_next          = phase_reg;
        length_high_next    = length_high_reg;
        body_length_next    = body_length_reg;
        body_remaining_next = body_remaining_reg;
        crc_high_next       = crc_high_reg;
        if (accept) begin
            unique case (phase_reg)
                PH_LEN_LO: begin
                    body_length_next = len_word;
                    if (len_word == 16'h0000 || too_long) begin
                        phase_next = PH_LEN_HI;
                    end else begin
                        body_remaining_next = len_word;
                        phase_next          = PH_CMD;
                    end
                end
                PH_CMD, PH_PAYLOAD: begin
                    body_remaining_next = remaining_dec;
                    phase_next = (remaining_dec == 16'h0000) ? PH_CRC_HI : PH_PAYLOAD;
                end
                PH_CRC_HI: begin
                    crc_high_next = s_rx_byte;
                    phase_next    = PH_CRC_LO;
                end
                PH_CRC_LO: begin
                    phase_next = PH_LEN_HI;
                end
                default: begin
                    length_high_next = s_rx_byte;
                    phase_next       = PH_LEN_LO;
                end
            endcase
        end
    end

    always_comb begin
        push_valid        = 1'b0;
        push_entry.op     = OP_CMD;
        push_entry.data   = s_rx_byte;
        push_entry.count  = 16'h0000;
        push_entry.rx_crc = {crc_high_reg, s_rx_byte};
        unique case (phase_reg)
            PH_LEN_LO: begin
                push_valid = accept;
                if (len_word == 16'h0000) begin
                    push_entry.op = OP_ZERO;
                end else begin
                    push_entry.op    = OP_LONG;
                    push_entry.count = len_word - 16'd1;
                end
                if (len_word != 16'h0000 && !too_long) begin
                    push_valid = 1'b0;
                end
            end
            PH_CMD: begin
                push_valid    = accept;
                push_entry.op = OP_CMD;
            end
            PH_PAYLOAD: begin
                push_valid    = accept;
                push_entry.op = OP_PAYLOAD;
            end
            PH_CRC_LO: begin
                push_valid       = accept;
                push_entry.op    = OP_CHECK;
                push_entry.count = body_length_reg - 16'd1;
            end
            default: begin
                push_valid = 1'b0;
            end
        endcase
    end

    `LPCD_ASSERT_NEXT(a_zero_length_restarts,
        accept && phase_reg == PH_LEN_LO && len_word == 16'h0000,
        phase_reg == PH_LEN_HI, "zero-length frame did not return to length wait")
    `LPCD_ASSERT_SAME(a_push_needs_transfer, push_valid,
        s_valid && s_ready, "operation queued without an input transfer")
    `LPCD_ASSERT_NEXT(a_body_end_to_crc,
        accept && (phase_reg == PH_CMD || phase_reg == PH_PAYLOAD) &&
        body_remaining_reg == 16'd1,
        phase_reg == PH_CRC_HI, "last body byte did not lead to the CRC bytes")

endmodule

FILE: hdl/lpcd_fifo.sv
// Short queue of classified operations between the front and back ends.
module lpcd_fifo
    import lpcd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_valid,
    output logic      push_ready,
    input  op_entry_t push_entry,
    output logic      pop_valid,
    input  logic      pop_ready,
    output op_entry_t pop_entry
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    op_entry_t        mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: hdl/lpcd_back.sv
// Back end: runs the CRC, checks it and drives the registered result channel.
`include "length_prefixed_crc_deframer_defines.svh"

module lpcd_back
    import lpcd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  op_entry_t   pop_entry,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_out_kind,
    output logic [7:0]  m_out_byte,
    output logic [1:0]  m_frame_status,
    output logic [15:0] m_payload_count,
    output logic        m_frame_end
);

    logic [15:0] crc_reg, crc_next;
    logic        m_valid_reg, m_valid_next;
    logic [1:0]  kind_reg, kind_next;
    logic [7:0]  byte_reg, byte_next;
    logic [1:0]  status_reg, status_next;
    logic [15:0] count_reg, count_next;
    logic        end_reg, end_next;
    logic        pop;

    assign pop_ready = !m_valid_reg || m_ready;
    assign pop       = pop_valid && pop_ready;

    always_comb begin
        crc_next     = crc_reg;
        m_valid_next = m_valid_reg && !m_ready;
        kind_next    = kind_reg;
        byte_next    = byte_reg;
        status_next  = status_reg;
        count_next   = count_reg;
        end_next     = end_reg;
        if (pop) begin
            m_valid_next = 1'b1;
            byte_next    = 8'h00;
            status_next  = ST_OK;
            count_next   = 16'h0000;
            end_next     = 1'b0;
            kind_next    = KIND_STATUS;
            unique case (pop_entry.op)
                OP_CMD: begin
                    crc_next  = crc_byte(16'h0000, pop_entry.data);
                    kind_next = KIND_CMD;
                    byte_next = pop_entry.data;
                end
                OP_PAYLOAD: begin
                    crc_next  = crc_byte(crc_reg, pop_entry.data);
                    kind_next = KIND_PAYLOAD;
                    byte_next = pop_entry.data;
                end
                OP_CHECK: begin
                    status_next = (pop_entry.rx_crc == crc_reg) ? ST_OK : ST_CRC;
                    count_next  = pop_entry.count;
                    end_next    = 1'b1;
                end
                OP_ZERO: begin
                    status_next = ST_ZERO;
                    end_next    = 1'b1;
                end
                default: begin
                    status_next = ST_LONG;
                    count_next  = pop_entry.count;
                    end_next    = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            crc_reg     <= 16'h0000;
        end else begin
            m_valid_reg <= m_valid_next;
            crc_reg     <= crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        byte_reg   <= byte_next;
        status_reg <= status_next;
        count_reg  <= count_next;
        end_reg    <= end_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_out_kind      = kind_reg;
    assign m_out_byte      = byte_reg;
    assign m_frame_status  = status_reg;
    assign m_payload_count = count_reg;
    assign m_frame_end     = end_reg;

    `LPCD_ASSERT_NEXT(a_check_gives_status, pop && pop_entry.op == OP_CHECK,
        m_valid && m_frame_end, "CRC check did not produce a closing status")
    `LPCD_ASSERT_NEXT(a_byte_not_closing,
        pop && (pop_entry.op == OP_CMD || pop_entry.op == OP_PAYLOAD),
        m_valid && !m_frame_end && m_frame_status == ST_OK,
        "body byte result marked as a status")
    `LPCD_ASSERT_SAME(a_pop_slot_free, pop, !m_valid_reg || m_ready,
        "operation taken while the result register was occupied")

endmodule
